// ===== hdl/sttq_pkg.sv =====
package sttq_pkg;

  localparam int TableDepthDef = 256;
  localparam int MaxResults    = 64;

  // command modes
  localparam logic [1:0] ModeCreate = 2'd0;
  localparam logic [1:0] ModeDelete = 2'd1;
  localparam logic [1:0] ModeExpire = 2'd2;

  // result status codes
  localparam logic [2:0] StCreated  = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StDeleted  = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StExpired  = 3'd4;
  localparam logic [2:0] StNoneDue  = 3'd5;

  // configuration register indexes
  localparam logic [3:0] RegMinDelay    = 4'd0;
  localparam logic [3:0] RegExpiryLimit = 4'd1;

  localparam logic [15:0] MinDelayRst    = 16'd1;
  localparam logic [6:0]  ExpiryLimitRst = 7'd10;
  localparam logic [6:0]  ExpiryLimitMax = 7'(MaxResults);

  // cell operations
  localparam logic [1:0] OpHold   = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpPop    = 2'd2;
  localparam logic [1:0] OpDelete = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] now_ms;
    logic [31:0] delay_ms;
    logic        one_shot;
    logic [31:0] target_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] target;
    logic [31:0] delay;
    logic        one_shot;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     bcast;
  } cell_ctrl_t;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

endpackage

// ===== hdl/sttq_cell.sv =====
module sttq_cell import sttq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  logic       lt_prev_i,
  input  logic       del_shift_i,
  input  entry_t     prev_i,
  input  entry_t     next_i,
  output entry_t     entry_o,
  output logic       lt_o,
  output logic       match_o
);

  entry_t entry_q, entry_d;

  assign lt_o    = valid_i && (entry_q.target < ctrl_i.bcast.target);
  assign match_o = valid_i && (entry_q.id == ctrl_i.bcast.id);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OpInsert: begin
        // keep earlier entries, take the new one at the boundary, shift the rest up
        if (!lt_o) begin
          entry_d = lt_prev_i ? ctrl_i.bcast : prev_i;
        end
      end
      OpPop:    entry_d = next_i;
      OpDelete: begin
        if (del_shift_i) begin
          entry_d = next_i;
        end
      end
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/sttq_scan.sv =====
module sttq_scan import sttq_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   step_i,
  input  logic [TABLE_DEPTH-1:0] match_i,
  output logic [TABLE_DEPTH-1:0] sfx_o,
  output logic                   done_o
);

  localparam int Lvl  = $clog2(TABLE_DEPTH);
  localparam int LvlW = (Lvl > 1) ? $clog2(Lvl) : 1;

  logic [TABLE_DEPTH-1:0] vec_q, vec_d;
  logic [LvlW-1:0]        lvl_q, lvl_d;

  assign sfx_o  = vec_q;
  assign done_o = step_i && (lvl_q == LvlW'(Lvl - 1));

  // suffix OR: one doubling level per cycle while step_i is high
  always_comb begin
    vec_d = vec_q;
    lvl_d = lvl_q;
    if (load_i) begin
      vec_d = match_i;
      lvl_d = '0;
    end else if (step_i) begin
      vec_d = vec_q | (vec_q >> (32'd1 << lvl_q));
      lvl_d = done_o ? '0 : lvl_q + LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else begin
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

endmodule

// ===== hdl/sorted_software_timer_queue.sv =====
// Sorted timer queue.
// Commands enter on cmd_i when start is high and busy is low. Each command
// produces its results on result_o, one per cycle between timer re-arms, flagged by
// result_valid_o; the receiver takes every result at once and cannot hold them off.
// Configuration writes (min delay, expiry limit) use the cfg channel, which is
// always ready; write only while busy is low.
// Timers sit in a chain of cells, earliest expiry in cell 0. Every cell
// compares its own entry with a broadcast entry, so an insert moves the whole
// chain together, and a pop shifts every cell toward cell 0.
// Step by step: create computes its result and then inserts the timer, still
// busy for the insert; delete loads the matches, runs the suffix-OR scan that
// finds the latest match and then shifts that entry out; expire pops each due
// timer and re-inserts every interval timer after its pop. A new command is
// taken on the first edge after busy drops. The last result of a command is
// marked by last; a mode 3 command gives no result.
// Reset empties the queue, sets the next identifier to 1 and loads the
// register defaults; the cell contents are not cleared.
module sorted_software_timer_queue import sttq_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        result_valid_o,
  output res_t        result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SCalc   = 3'd1;
  localparam logic [2:0] SIns    = 3'd2;
  localparam logic [2:0] SDMatch = 3'd3;
  localparam logic [2:0] SDScan  = 3'd4;
  localparam logic [2:0] SDDone  = 3'd5;
  localparam logic [2:0] SEChk   = 3'd6;

  logic [2:0]  state_q, state_d;
  cmd_t        in_q, in_d;
  entry_t      ins_q, ins_d;
  logic        ret_exp_q, ret_exp_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] next_id_q, next_id_d;
  logic [15:0] min_delay_q;
  logic [6:0]  limit_cfg_q, limit_q, limit_d;
  logic [6:0]  n_q, n_d;
  logic        pend_q, pend_d;
  logic [31:0] pend_id_q, pend_id_d;
  logic        res_valid_q, res_valid_d;
  res_t        res_q, res_d;

  cell_ctrl_t             ctrl;
  entry_t                 entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt, match, sfx;
  logic                   scan_load, scan_step, scan_done;

  logic [31:0] eff_delay, add_delay;
  logic [47:0] add_sum;
  logic        due;

  assign busy           = (state_q != SIdle);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign eff_delay = (in_q.delay_ms < {16'd0, min_delay_q}) ? {16'd0, min_delay_q}
                                                           : in_q.delay_ms;
  assign add_delay = (state_q == SCalc) ? eff_delay : entries[0].delay;
  assign add_sum   = sat_add(in_q.now_ms, add_delay);
  assign due       = (n_q < limit_q) && (count_q != '0) && !(entries[0].target > in_q.now_ms);

  sttq_scan #(.TABLE_DEPTH(TABLE_DEPTH)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .step_i  (scan_step),
    .match_i (match),
    .sfx_o   (sfx),
    .done_o  (scan_done)
  );

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic   lt_prev, del_shift;
    entry_t prev_e, next_e;
    if (k == 0) begin : g_head
      assign lt_prev = 1'b1;
      assign prev_e  = ctrl.bcast;
    end else begin : g_body
      assign lt_prev = lt[k-1];
      assign prev_e  = entries[k-1];
    end
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign next_e    = entries[k];
      assign del_shift = 1'b1;
    end else begin : g_mid
      assign next_e    = entries[k+1];
      assign del_shift = !sfx[k+1];
    end
    sttq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (CW'(k) < count_q),
      .lt_prev_i   (lt_prev),
      .del_shift_i (del_shift),
      .prev_i      (prev_e),
      .next_i      (next_e),
      .entry_o     (entries[k]),
      .lt_o        (lt[k]),
      .match_o     (match[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    ins_d       = ins_q;
    ret_exp_d   = ret_exp_q;
    count_d     = count_q;
    next_id_d   = next_id_q;
    limit_d     = limit_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    scan_load   = 1'b0;
    scan_step   = 1'b0;
    ctrl.op     = OpHold;
    ctrl.bcast  = ins_q;

    case (state_q)
      SIdle: begin
        if (start) begin
          in_d    = cmd_i;
          n_d     = '0;
          pend_d  = 1'b0;
          limit_d = (limit_cfg_q > ExpiryLimitMax) ? ExpiryLimitMax : limit_cfg_q;
          case (cmd_i.mode)
            ModeCreate: state_d = SCalc;
            ModeDelete: state_d = SDMatch;
            ModeExpire: state_d = SEChk;
            default:    state_d = SIdle;
          endcase
        end
      end
      SCalc: begin
        res_valid_d = 1'b1;
        if (count_q == CW'(TABLE_DEPTH)) begin
          res_d   = '{status: StFull, result_id: 32'd0, last: 1'b1};
          state_d = SIdle;
        end else begin
          res_d     = '{status: StCreated, result_id: next_id_q, last: 1'b1};
          ins_d     = '{id: next_id_q, target: add_sum, delay: eff_delay,
                        one_shot: in_q.one_shot};
          next_id_d = next_id_q + 32'd1;
          ret_exp_d = 1'b0;
          state_d   = SIns;
        end
      end
      SIns: begin
        ctrl.op = OpInsert;
        count_d = count_q + CW'(1);
        state_d = ret_exp_q ? SEChk : SIdle;
      end
      SDMatch: begin
        ctrl.bcast.id = in_q.target_id;
        scan_load     = 1'b1;
        state_d       = SDScan;
      end
      SDScan: begin
        scan_step = 1'b1;
        if (scan_done) begin
          state_d = SDDone;
        end
      end
      SDDone: begin
        res_valid_d = 1'b1;
        state_d     = SIdle;
        if (sfx[0]) begin
          ctrl.op = OpDelete;
          count_d = count_q - CW'(1);
          res_d   = '{status: StDeleted, result_id: 32'd0, last: 1'b1};
        end else begin
          res_d   = '{status: StNotFound, result_id: 32'd0, last: 1'b1};
        end
      end
      SEChk: begin
        if (due) begin
          // hold one result back so the final one can carry last
          if (pend_q) begin
            res_valid_d = 1'b1;
            res_d       = '{status: StExpired, result_id: pend_id_q, last: 1'b0};
          end
          pend_d    = 1'b1;
          pend_id_d = entries[0].id;
          n_d       = n_q + 7'd1;
          ctrl.op   = OpPop;
          count_d   = count_q - CW'(1);
          if (!entries[0].one_shot) begin
            ins_d     = '{id: entries[0].id, target: add_sum, delay: entries[0].delay,
                          one_shot: 1'b0};
            ret_exp_d = 1'b1;
            state_d   = SIns;
          end
        end else begin
          res_valid_d = 1'b1;
          if (pend_q) begin
            res_d = '{status: StExpired, result_id: pend_id_q, last: 1'b1};
          end else begin
            res_d = '{status: StNoneDue, result_id: 32'd0, last: 1'b1};
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      next_id_q   <= 32'd1;
      min_delay_q <= MinDelayRst;
      limit_cfg_q <= ExpiryLimitRst;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      ret_exp_q   <= 1'b0;
      n_q         <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_id_q   <= next_id_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      ret_exp_q   <= ret_exp_d;
      n_q         <= n_d;
      limit_q     <= limit_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == RegMinDelay) begin
          min_delay_q <= cfg_data_i;
        end else if (cfg_index_i == RegExpiryLimit) begin
          limit_cfg_q <= cfg_data_i[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    ins_q     <= ins_d;
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

endmodule

// ===== tb/sorted_software_timer_queue_tb.sv =====
`timescale 1ns / 1ps
module sorted_software_timer_queue_tb import sttq_pkg::*;;

  localparam int Depth = 256;
  localparam int WatchLimit = 20000;
  localparam logic [1:0] ModeUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic result_valid_o;
  res_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  sorted_software_timer_queue #(.TABLE_DEPTH(Depth)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // timer table of the predictor, earliest expiry at the highest index
  logic [31:0] tm_id[Depth];
  logic [47:0] tm_target[Depth];
  logic [31:0] tm_delay[Depth];
  logic tm_one_shot[Depth];
  int tm_count;
  logic [31:0] next_id;
  logic [15:0] shortest_delay;
  logic [6:0] expiry_limit;

  res_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;

  function automatic logic [47:0] expiry_of(logic [47:0] now, logic [31:0] dl);
    logic [48:0] s;
    s = {1'b0, now} + {17'd0, dl};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic void insert_timer(logic [31:0] id, logic [47:0] tg, logic [31:0] dl,
                                       logic os);
    int i;
    i = tm_count;
    tm_count++;
    while (i > 0 && tg > tm_target[i-1]) begin
      tm_id[i] = tm_id[i-1];
      tm_target[i] = tm_target[i-1];
      tm_delay[i] = tm_delay[i-1];
      tm_one_shot[i] = tm_one_shot[i-1];
      i--;
    end
    tm_id[i] = id;
    tm_target[i] = tg;
    tm_delay[i] = dl;
    tm_one_shot[i] = os;
  endfunction

  function automatic void push_result(logic [2:0] st, logic [31:0] id, logic lst);
    res_t r;
    r.status = st;
    r.result_id = id;
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_queue(cmd_t c);
    logic [31:0] dl;
    logic [31:0] top_id;
    int lim, n, top;
    bit found;
    case (c.mode)
      ModeCreate: begin
        dl = c.delay_ms < {16'd0, shortest_delay} ? {16'd0, shortest_delay} : c.delay_ms;
        if (tm_count >= Depth) begin
          push_result(StFull, '0, 1'b1);
        end else begin
          insert_timer(next_id, expiry_of(c.now_ms, dl), dl, c.one_shot);
          push_result(StCreated, next_id, 1'b1);
          next_id++;
        end
      end
      ModeDelete: begin
        found = 0;
        for (int i = 0; i < tm_count; i++) begin
          if (!found && tm_id[i] == c.target_id) begin
            found = 1;
            for (int j = i; j + 1 < tm_count; j++) begin
              tm_id[j] = tm_id[j+1];
              tm_target[j] = tm_target[j+1];
              tm_delay[j] = tm_delay[j+1];
              tm_one_shot[j] = tm_one_shot[j+1];
            end
          end
        end
        if (found) tm_count--;
        push_result(found ? StDeleted : StNotFound, '0, 1'b1);
      end
      ModeExpire: begin
        lim = expiry_limit > MaxResults ? MaxResults : expiry_limit;
        n = 0;
        while (n < lim && tm_count > 0) begin
          top = tm_count - 1;
          if (tm_target[top] > c.now_ms) break;
          top_id = tm_id[top];
          tm_count = top;
          if (!tm_one_shot[top])
            insert_timer(top_id, expiry_of(c.now_ms, tm_delay[top]), tm_delay[top], 1'b0);
          push_result(StExpired, top_id, 1'b0);
          n++;
        end
        if (n == 0) push_result(StNoneDue, '0, 1'b1);
        else expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result status=%0d id=%0d", result_o.status, result_o.result_id);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result_o.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, result_o.status);
          errors++;
        end
        if (result_o.result_id !== e.result_id) begin
          $error("result_id expected %0d actual %0d", e.result_id, result_o.result_id);
          errors++;
        end
        if (result_o.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, result_o.last);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_cmd(cmd_t c);
    @(negedge clk_i);
    if (send_gap > 0 && $urandom_range(99) < send_gap) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_queue(c);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegMinDelay) shortest_delay = val;
    else if (idx == RegExpiryLimit) expiry_limit = val[6:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cmd_t make_cmd(logic [1:0] m, logic [47:0] now, logic [31:0] dl, logic os,
                                    logic [31:0] tid);
    cmd_t c;
    c.mode = m;
    c.now_ms = now;
    c.delay_ms = dl;
    c.one_shot = os;
    c.target_id = tid;
    return c;
  endfunction

  function automatic logic [47:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  task automatic test_directed();
    send_cmd(make_cmd(ModeExpire, '0, '0, 1'b0, '0));
    send_cmd(make_cmd(ModeCreate, 48'd100, 32'd0, 1'b1, '0));
    send_cmd(make_cmd(ModeCreate, 48'd100, 32'd1, 1'b1, '0));
    send_cmd(make_cmd(ModeCreate, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ModeCreate, 48'd50, 32'd10, 1'b0, '0));
    send_cmd(make_cmd(ModeUnused, rand_time(), $urandom(), 1'b1, $urandom()));
    send_cmd(make_cmd(ModeDelete, '0, '0, 1'b0, 32'd3));
    send_cmd(make_cmd(ModeDelete, '0, '0, 1'b0, 32'd3));
    send_cmd(make_cmd(ModeDelete, '0, '0, 1'b0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ModeExpire, 48'd200, '0, 1'b0, '0));
    send_cmd(make_cmd(ModeExpire, 48'hFFFF_FFFF_FFFF, '0, 1'b1, '0));
    write_reg(RegMinDelay, 16'd0);
    send_cmd(make_cmd(ModeCreate, 48'd10, 32'd0, 1'b0, '0));
    send_cmd(make_cmd(ModeExpire, 48'd10, '0, 1'b0, '0));
    write_reg(RegExpiryLimit, 16'd0);
    send_cmd(make_cmd(ModeExpire, 48'd10, '0, 1'b0, '0));
    write_reg(RegExpiryLimit, 16'd127);
    send_cmd(make_cmd(ModeExpire, 48'd10, '0, 1'b0, '0));
    send_cmd(make_cmd(ModeDelete, '0, '0, 1'b0, 32'd5));
    // drop the remaining interval timer so the table can drain later
    send_cmd(make_cmd(ModeDelete, '0, '0, 1'b0, 32'd4));
  endtask

  // fill to capacity and provoke table full
  task automatic test_full_table();
    write_reg(RegMinDelay, 16'hFFFF);
    while (tm_count < Depth)
      send_cmd(make_cmd(ModeCreate, 48'($urandom_range(0, 1000)), $urandom_range(0, 70000),
                        1'b1, '0));
    send_cmd(make_cmd(ModeCreate, '0, '0, 1'b0, '0));
    write_reg(RegExpiryLimit, 16'd64);
    while (tm_count > 0)
      send_cmd(make_cmd(ModeExpire, 48'hFFFF_FFFF_FFFF, '0, 1'b0, '0));
  endtask

  task automatic test_id_wrap();
    // advance identifiers through create and delete pairs
    write_reg(RegMinDelay, 16'd1);
    repeat (4) begin
      send_cmd(make_cmd(ModeCreate, '0, $urandom_range(0, 50), 1'b1, '0));
      send_cmd(make_cmd(ModeDelete, '0, '0, 1'b0, next_id - 1));
    end
  endtask

  task automatic test_random(int items);
    cmd_t c;
    logic [47:0] now;
    int pick;
    now = 48'd1000;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      now = now + 48'($urandom_range(0, 40));
      if (pick < 45) begin
        c = make_cmd(ModeCreate, now, $urandom_range(0, 3) == 0 ? $urandom() :
                     $urandom_range(0, 120), 1'($urandom()), $urandom());
      end else if (pick < 65) begin
        c = make_cmd(ModeDelete, rand_time(), $urandom(), 1'($urandom()),
                     (tm_count > 0 && $urandom_range(3) != 0) ?
                     tm_id[$urandom_range(0, tm_count - 1)] : $urandom());
      end else if (pick < 95) begin
        c = make_cmd(ModeExpire, now, $urandom(), 1'($urandom()), $urandom());
      end else begin
        c = make_cmd(pick < 98 ? ModeExpire : ModeUnused, rand_time(), $urandom(),
                     1'($urandom()), $urandom());
      end
      send_cmd(c);
      if (k == items / 2) drain_results();
    end
  endtask

  initial begin
    tm_count = 0;
    next_id = 32'd1;
    shortest_delay = MinDelayRst;
    expiry_limit = ExpiryLimitRst;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_gap = 10;
    test_directed();
    test_full_table();
    test_id_wrap();
    test_random(10);
    send_gap = 58;
    write_reg(RegMinDelay, 16'd5);
    write_reg(RegExpiryLimit, 16'd1);
    test_random(10);
    send_gap = 0;
    write_reg(RegMinDelay, 16'd0);
    write_reg(RegExpiryLimit, 16'd64);
    test_random(10);
    drain_results();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
